// ===== rtl/fos_pkg.sv =====
// ----------------------------------------------------------------------------
// fos_pkg
// Shared types, constants and the coefficient table of the 55-tap FIR with
// switch-selected output.
// ----------------------------------------------------------------------------
package fos_pkg;

    localparam int TAPS        = 55;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int COEF_LEN    = 55;
    localparam int FRAC_BITS   = 15;
    localparam int TAP_BITS    = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS    = PROD_BITS + TAP_BITS;
    localparam int DRAIN_CYCLES = 2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;
    typedef logic [TAP_BITS-1:0]           tap_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_DRAIN,
        SEQ_DONE
    } seq_state_t;

    typedef struct packed {
        logic clear;
        logic issue;
        logic tap_live;
        tap_t tap;
    } mac_ctl_t;

    localparam coef_t COEF_TABLE [COEF_LEN] = '{
            16'sd0,    16'sd231,      16'sd0,   -16'sd359,      16'sd0,
          16'sd457,      16'sd0,   -16'sd478,      16'sd0,    16'sd376,
            16'sd0,   -16'sd115,      16'sd0,   -16'sd319,      16'sd0,
          16'sd915,      16'sd0,  -16'sd1630,      16'sd0,   16'sd2394,
            16'sd0,  -16'sd3122,      16'sd0,   16'sd3724,      16'sd0,
        -16'sd4121,      16'sd0,   16'sd4260,      16'sd0,  -16'sd4121,
            16'sd0,   16'sd3724,      16'sd0,  -16'sd3122,      16'sd0,
         16'sd2394,      16'sd0,  -16'sd1630,      16'sd0,    16'sd915,
            16'sd0,   -16'sd319,      16'sd0,   -16'sd115,      16'sd0,
          16'sd376,      16'sd0,   -16'sd478,      16'sd0,    16'sd457,
            16'sd0,   -16'sd359,      16'sd0,    16'sd231,      16'sd0
    };

    // taps beyond the table carry a zero coefficient
    function automatic coef_t coef_at(tap_t k);
        coef_t c;
        c = '0;
        if (int'(k) < COEF_LEN)
        begin
            c = COEF_TABLE[int'(k)];
        end
        return c;
    endfunction

endpackage

// ===== rtl/fos_if.sv =====
// ----------------------------------------------------------------------------
// fos_in_if / fos_out_if
// Valid/ready channels carrying the input sample with switch levels, and the
// selected output sample.
// ----------------------------------------------------------------------------
interface fos_in_if
    import fos_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample_in;
    logic    switch_zero;
    logic    switch_one;

    modport source (output valid, output sample_in, output switch_zero,
                    output switch_one, input ready);
    modport sink   (input valid, input sample_in, input switch_zero,
                    input switch_one, output ready);
endinterface

interface fos_out_if
    import fos_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/fir_filter_with_output_select_core.sv =====
// ----------------------------------------------------------------------------
// fir_filter_with_output_select_core
// 55-tap direct-form FIR over a RAM-based delay line, with the output picked
// by two switch levels: bypass, filtered or zero.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. From acceptance to a loaded
// result, the core takes the sample and writes it to the delay store, runs
// one multiply-accumulate per tap through the single read port of the store,
// lets the MAC pipeline drain and loads the output register. The next item is
// taken in the cycle after the result is loaded, while that result may still
// wait to be taken; the result is held in the output register, and only when
// it is still unclaimed at the end of the following item does the core wait.
// The delay line reads as zero after reset. Filtered values are the Q1.15 sum
// scaled by 2^-15, truncated toward zero and saturated to 16 bits.
// ----------------------------------------------------------------------------
module fir_filter_with_output_select_core
    import fos_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    fos_in_if.sink           in_item,
    fos_out_if.source        out_item
);

    logic     accept;
    logic     out_free;
    logic     done;
    logic     wr_en;
    tap_t     wr_addr;
    logic     rd_en;
    tap_t     rd_addr;
    sample_t  rd_data;
    mac_ctl_t ctl;
    sample_t  filtered;

    sample_t  x_reg;
    logic     sw0_reg;
    logic     sw1_reg;
    logic     out_valid_reg, out_valid_next;
    sample_t  out_data_reg, out_data_next;

    assign accept   = in_item.valid && in_item.ready;
    assign out_free = !out_valid_reg || out_item.ready;

    fos_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_item.valid),
        .in_ready (in_item.ready),
        .out_free (out_free),
        .done     (done),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .ctl      (ctl)
    );

    fos_delay_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (in_item.sample_in),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fos_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rd_data  (rd_data),
        .filtered (filtered)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg   <= in_item.sample_in;
            sw0_reg <= in_item.switch_zero;
            sw1_reg <= in_item.switch_one;
        end
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_item.ready;
        out_data_next  = out_data_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
            priority if (!sw0_reg)
            begin
                out_data_next = x_reg;
            end
            else if (!sw1_reg)
            begin
                out_data_next = filtered;
            end
            else
            begin
                out_data_next = '0;
            end
        end
    end

    assign out_item.valid      = out_valid_reg;
    assign out_item.sample_out = out_data_reg;

endmodule

// ===== rtl/fos_delay_mem.sv =====
// ----------------------------------------------------------------------------
// fos_delay_mem
// Circular sample store for the delay line: one write port, one read port
// with registered read data.
// ----------------------------------------------------------------------------
module fos_delay_mem
    import fos_pkg::*;
(
    input  logic    clk,
    input  logic    wr_en,
    input  tap_t    wr_addr,
    input  sample_t wr_data,
    input  logic    rd_en,
    input  tap_t    rd_addr,
    output sample_t rd_data
);

    sample_t mem [TAPS];
    sample_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/fos_mac.sv =====
// ----------------------------------------------------------------------------
// fos_mac
// Coefficient lookup, multiplier and accumulator, followed by the scaling
// (truncation toward zero) and saturation of the accumulated sum.
// ----------------------------------------------------------------------------
module fos_mac
    import fos_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mac_ctl_t ctl,
    input  sample_t  rd_data,
    output sample_t  filtered
);

    localparam acc_t ROUND_BIAS = acc_t'((2 ** FRAC_BITS) - 1);
    localparam acc_t SAT_MAX    = acc_t'((2 ** (SAMPLE_BITS - 1)) - 1);
    localparam acc_t SAT_MIN    = acc_t'(-(2 ** (SAMPLE_BITS - 1)));

    logic  s1_valid_reg;
    logic  s2_valid_reg;
    logic  live_reg;
    coef_t coef_reg;
    prod_t prod_reg;
    acc_t  acc_reg;
    acc_t  acc_next;
    acc_t  scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= ctl.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // taps not yet written contribute nothing, whatever the store returns
    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            coef_reg <= ctl.tap_live ? coef_at(ctl.tap) : '0;
            live_reg <= ctl.tap_live;
        end
        if (s1_valid_reg)
        begin
            if (live_reg)
            begin
                prod_reg <= rd_data * coef_reg;
            end
            else
            begin
                prod_reg <= '0;
            end
        end
        acc_reg <= acc_next;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (s2_valid_reg)
        begin
            acc_next = acc_reg + acc_t'(prod_reg);
        end
    end

    always_comb
    begin
        scaled = (acc_reg + (acc_reg[ACC_BITS-1] ? ROUND_BIAS : acc_t'(0))) >>> FRAC_BITS;
        if (scaled > SAT_MAX)
        begin
            filtered = SAT_MAX[SAMPLE_BITS-1:0];
        end
        else if (scaled < SAT_MIN)
        begin
            filtered = SAT_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            filtered = scaled[SAMPLE_BITS-1:0];
        end
    end

endmodule

// ===== rtl/fos_seq.sv =====
// ----------------------------------------------------------------------------
// fos_seq
// Sequencer: takes a transaction, writes the sample, walks the taps through
// the store, waits for the MAC pipeline to drain, then releases the result.
// Tracks the write pointer and how much of the history has been filled.
// ----------------------------------------------------------------------------
module fos_seq
    import fos_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic     out_free,
    output logic     done,
    output logic     wr_en,
    output tap_t     wr_addr,
    output logic     rd_en,
    output tap_t     rd_addr,
    output mac_ctl_t ctl
);

    localparam tap_t LAST_TAP = tap_t'(TAPS - 1);
    localparam logic [1:0] LAST_DRAIN = 2'(DRAIN_CYCLES - 1);

    seq_state_t state_reg, state_next;
    tap_t       tap_reg, tap_next;
    tap_t       rd_addr_reg, rd_addr_next;
    tap_t       wr_ptr_reg, wr_ptr_next;
    tap_t       fill_reg, fill_next;
    logic [1:0] drain_reg, drain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= SEQ_IDLE;
            tap_reg     <= '0;
            rd_addr_reg <= '0;
            wr_ptr_reg  <= '0;
            fill_reg    <= '0;
            drain_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            tap_reg     <= tap_next;
            rd_addr_reg <= rd_addr_next;
            wr_ptr_reg  <= wr_ptr_next;
            fill_reg    <= fill_next;
            drain_reg   <= drain_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        tap_next     = tap_reg;
        rd_addr_next = rd_addr_reg;
        wr_ptr_next  = wr_ptr_reg;
        fill_next    = fill_reg;
        drain_next   = drain_reg;
        in_ready     = 1'b0;
        done         = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        ctl          = '0;
        ctl.tap      = tap_reg;
        ctl.tap_live = (tap_reg <= fill_reg);

        unique case (state_reg)
            SEQ_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    wr_en        = 1'b1;
                    ctl.clear    = 1'b1;
                    tap_next     = '0;
                    rd_addr_next = wr_ptr_reg;
                    state_next   = SEQ_RUN;
                end
            end
            SEQ_RUN:
            begin
                rd_en        = 1'b1;
                ctl.issue    = 1'b1;
                tap_next     = tap_reg + 1'b1;
                rd_addr_next = (rd_addr_reg == '0) ? LAST_TAP : rd_addr_reg - 1'b1;
                if (tap_reg == LAST_TAP)
                begin
                    drain_next = '0;
                    state_next = SEQ_DRAIN;
                end
            end
            SEQ_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == LAST_DRAIN)
                begin
                    state_next = SEQ_DONE;
                end
            end
            SEQ_DONE:
            begin
                if (out_free)
                begin
                    done        = 1'b1;
                    wr_ptr_next = (wr_ptr_reg == LAST_TAP) ? '0 : wr_ptr_reg + 1'b1;
                    if (fill_reg != LAST_TAP)
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    assign wr_addr = wr_ptr_reg;
    assign rd_addr = rd_addr_reg;

endmodule

// ===== rtl/fos_checker.sv =====
// ----------------------------------------------------------------------------
// fos_checker
// Port-level checks on the FIR core, attached to the top level by bind.
// ----------------------------------------------------------------------------
module fos_checker
    import fos_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t sample_out
);

    // an unclaimed result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out))
        else $error("output changed while stalled");

    // one item in flight: no transaction right after another
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in progress");

    // a result needs a pass over all taps, so no result follows acceptance at once
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after acceptance");

endmodule

bind fir_filter_with_output_select_core fos_checker u_fos_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_item.valid),
    .in_ready   (in_item.ready),
    .out_valid  (out_item.valid),
    .out_ready  (out_item.ready),
    .sample_out (out_item.sample_out)
);

// ===== test/fir_filter_with_output_select_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_filter_with_output_select_core_tb
// Streams audio samples with switch levels through the 55-tap FIR core and
// checks every output transaction against a cycle-free filter predictor, under
// phases of source idling, sink stalling and one long sink hold-off.
// ----------------------------------------------------------------------------
module fir_filter_with_output_select_core_tb;
    import fos_pkg::*;

    typedef struct {
        sample_t sample;
        logic    sw0;
        logic    sw1;
    } audio_item_t;

    typedef enum int {
        PH_STEADY,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH
    } idle_phase_t;

    localparam int      CLK_HALF     = 5;
    localparam int      RESET_CYCLES = 7;
    localparam int      TARGET_ITEMS = 1550;
    localparam int      PHASE_ITEMS  = 190;
    localparam int      HOLD_AT      = 800;
    localparam int      HOLD_CYCLES  = 600;
    localparam int      QUIET_LIMIT  = 4000;
    localparam int      SETTLE       = 80;
    localparam sample_t S_MAX        = 16'sh7fff;
    localparam sample_t S_MIN        = 16'sh8000;

    logic clk = 1'b0;
    logic rst_n;

    fos_in_if  in_item();
    fos_out_if out_item();

    fir_filter_with_output_select_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .out_item (out_item)
    );

    int tap_weight [55] = '{
            0,   231,     0,  -359,     0,   457,     0,  -478,     0,   376,
            0,  -115,     0,  -319,     0,   915,     0, -1630,     0,  2394,
            0, -3122,     0,  3724,     0, -4121,     0,  4260,     0, -4121,
            0,  3724,     0, -3122,     0,  2394,     0, -1630,     0,   915,
            0,  -319,     0,  -115,     0,   376,     0,  -478,     0,   457,
            0,  -359,     0,   231,     0
    };

    sample_t     tap_hist [TAPS];
    audio_item_t pending_items [$];
    audio_item_t cur_item;
    sample_t     expected_out [$];
    int          total_items = 0;
    int          in_count    = 0;
    int          out_count   = 0;
    int          errors      = 0;
    int          hold_left   = 0;
    logic        hold_used   = 1'b0;
    int          quiet       = 0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // advances the delay line and returns the switch-selected sample
    function automatic sample_t filter_and_select(audio_item_t it);
        longint  acc;
        longint  filt;
        sample_t sel;
        acc = 0;
        tap_hist[0] = it.sample;
        for (int k = 0; k < TAPS; k++)
        begin
            acc += longint'(k < 55 ? tap_weight[k] : 0) * longint'(tap_hist[k]);
        end
        for (int k = TAPS - 1; k > 0; k--)
        begin
            tap_hist[k] = tap_hist[k-1];
        end
        filt = acc / 32768;
        if (filt > longint'(S_MAX))
            filt = longint'(S_MAX);
        else if (filt < longint'(S_MIN))
            filt = longint'(S_MIN);
        if (!it.sw0)
            sel = it.sample;
        else if (!it.sw1)
            sel = sample_t'(filt);
        else
            sel = '0;
        return sel;
    endfunction

    function automatic idle_phase_t idle_phase();
        return idle_phase_t'((in_count / PHASE_ITEMS) % 4);
    endfunction

    function automatic logic sender_rests();
        idle_phase_t ph;
        ph = idle_phase();
        if (ph == PH_SRC_IDLE)
            return $urandom_range(99) < 64;
        if (ph == PH_BOTH)
            return $urandom_range(99) < 30;
        return 1'b0;
    endfunction

    function automatic logic receiver_stalls();
        idle_phase_t ph;
        ph = idle_phase();
        if (ph == PH_SNK_STALL)
            return $urandom_range(99) < 64;
        if (ph == PH_BOTH)
            return $urandom_range(99) < 30;
        return 1'b0;
    endfunction

    // {sw0, sw1}: filtered with the given weight, else bypass or muted
    function automatic logic [1:0] pick_switches(int filt_pct);
        int r;
        r = $urandom_range(99);
        if (r < filt_pct)
            return 2'b10;
        if (r < filt_pct + (100 - filt_pct) / 2)
            return {1'b0, 1'($urandom_range(1))};
        return 2'b11;
    endfunction

    task automatic add_item(sample_t s, logic [1:0] sw);
        audio_item_t it;
        it.sample = s;
        it.sw0    = sw[1];
        it.sw1    = sw[0];
        pending_items.push_back(it);
    endtask

    // source side
    always @(posedge clk or negedge rst_n)
    begin : source_drv
        logic offering;
        if (!rst_n)
        begin
            in_item.valid       <= 1'b0;
            in_item.sample_in   <= '0;
            in_item.switch_zero <= 1'b0;
            in_item.switch_one  <= 1'b0;
            in_count            <= 0;
            for (int k = 0; k < TAPS; k++)
                tap_hist[k] = '0;
        end
        else
        begin
            offering = in_item.valid;
            if (in_item.valid && in_item.ready)
            begin
                expected_out.push_back(filter_and_select(cur_item));
                in_count <= in_count + 1;
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (pending_items.size() > 0 && !sender_rests())
                begin
                    cur_item = pending_items.pop_front();
                    in_item.valid       <= 1'b1;
                    in_item.sample_in   <= cur_item.sample;
                    in_item.switch_zero <= cur_item.sw0;
                    in_item.switch_one  <= cur_item.sw1;
                end
                else
                begin
                    in_item.valid <= 1'b0;
                end
            end
        end
    end

    // long sink hold-off once the stream is well under way
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (!hold_used && in_count >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // sink side and checking
    always @(posedge clk or negedge rst_n)
    begin : sink_mon
        sample_t want;
        if (!rst_n)
        begin
            out_item.ready <= 1'b0;
            out_count      <= 0;
        end
        else
        begin
            if (out_item.valid && out_item.ready)
            begin
                if (out_count >= in_count)
                begin
                    errors++;
                    $display("%0t: unexpected output transaction, sample_out %0d",
                             $time, $signed(out_item.sample_out));
                end
                else
                begin
                    want = expected_out.pop_front();
                    out_count <= out_count + 1;
                    if (out_item.sample_out !== want)
                    begin
                        errors++;
                        $display("%0t: sample_out mismatch on item %0d: expected %0d, got %0d",
                                 $time, out_count, $signed(want),
                                 $signed(out_item.sample_out));
                    end
                end
            end
            out_item.ready <= (hold_left == 0) && !receiver_stalls();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_item.valid && in_item.ready) || (out_item.valid && out_item.ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, quiet);
                $display("[fir_filter_with_output_select_core] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        sample_t    dir_val [6];
        sample_t    v;
        int         kind;
        int         len;
        logic       neg;
        logic [1:0] sw;

        rst_n               = 1'b0;
        in_item.valid       = 1'b0;
        in_item.sample_in   = '0;
        in_item.switch_zero = 1'b0;
        in_item.switch_one  = 1'b0;
        out_item.ready      = 1'b0;

        // extremes under every switch setting
        dir_val = '{S_MAX, S_MIN, 16'sd0, 16'sd1, -16'sd1, 16'sh5555};
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 6; i++)
                add_item(dir_val[i], 2'(c));

        while (pending_items.size() < TARGET_ITEMS)
        begin
            kind = $urandom_range(0, 7);
            case (kind)
                0, 1, 2:
                begin
                    len = $urandom_range(10, 60);
                    for (int j = 0; j < len; j++)
                        add_item(sample_t'($urandom), pick_switches(55));
                end
                3:
                begin
                    // samples line up with coefficient signs: drives into saturation
                    neg = 1'($urandom_range(1));
                    for (int j = 0; j < TAPS + 4; j++)
                    begin
                        if (j >= TAPS || tap_weight[TAPS-1-j] == 0)
                            v = sample_t'($urandom);
                        else if ((tap_weight[TAPS-1-j] > 0) ^ neg)
                            v = S_MAX;
                        else
                            v = S_MIN;
                        add_item(v, pick_switches(85));
                    end
                end
                4:
                begin
                    v = $urandom_range(1) ? S_MAX : S_MIN;
                    add_item(v, pick_switches(85));
                    for (int j = 1; j < TAPS; j++)
                        add_item('0, pick_switches(85));
                end
                5:
                begin
                    len = $urandom_range(10, 40);
                    for (int j = 0; j < len; j++)
                        add_item(sample_t'($urandom_range(0, 63) - 32), pick_switches(55));
                end
                6:
                begin
                    len = $urandom_range(10, 60);
                    for (int j = 0; j < len; j++)
                        add_item(j[0] ? S_MIN : S_MAX, pick_switches(70));
                end
                default:
                begin
                    len = $urandom_range(TAPS, TAPS + 20);
                    v = sample_t'($urandom);
                    for (int j = 0; j < len; j++)
                        add_item(v, pick_switches(70));
                end
            endcase
        end
        total_items = pending_items.size();

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        wait (in_count == total_items);
        wait (out_count == in_count);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        if (errors == 0)
            $display("[fir_filter_with_output_select_core] OK");
        else
            $display("[fir_filter_with_output_select_core] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fos_pkg.sv
rtl/fos_if.sv
rtl/fos_delay_mem.sv
rtl/fos_mac.sv
rtl/fos_seq.sv
rtl/fir_filter_with_output_select_core.sv
rtl/fos_checker.sv
test/fir_filter_with_output_select_core_tb.sv
